// ===== rtl/jit_pkg.sv =====
`default_nettype none

package jit_pkg;

   // table geometry
   localparam int MAX_JOBS = 16;
   localparam int SLOT_W   = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   // beat field widths
   localparam int OP_W     = 2;
   localparam int ID_W     = 5;
   localparam int PID_W    = 31;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_FIND_ID  = 2'd2,
      OP_FIND_PID = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // decision for one command, from the match logic to the table registers
   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      status_type        status;
      logic              set_slot;
      logic              clr_slot;
   } match_type;

endpackage

`default_nettype wire

// ===== rtl/jit_match.sv =====
`default_nettype none

module jit_match import jit_pkg::*; (
   input  wire op_type             op,
   input  wire logic [ID_W-1:0]    job_id,
   input  wire logic [PID_W-1:0]   proc_id,
   input  wire logic [MAX_JOBS-1:0] slot_valid,
   input  wire logic [PID_W-1:0]   slot_pid [MAX_JOBS],
   output match_type               match
);

   // lowest set bit: {found, index}
   function automatic logic [SLOT_W:0] lowest_set(input logic [MAX_JOBS-1:0] vec);
      logic [SLOT_W:0] res;
      res = '0;
      for (int k = MAX_JOBS - 1; k >= 0; k--) begin
         if (vec[k]) begin
            res = {1'b1, SLOT_W'(k)};
         end
      end
      return res;
   endfunction

   logic [MAX_JOBS-1:0] pid_hits;
   logic [SLOT_W:0]     free_enc;
   logic [SLOT_W:0]     pid_enc;
   logic                id_ok;
   logic [SLOT_W-1:0]   id_slot;
   logic                id_hit;

   always_comb begin
      for (int k = 0; k < MAX_JOBS; k++) begin
         pid_hits[k] = slot_valid[k] && (slot_pid[k] == proc_id);
      end
      free_enc = lowest_set(~slot_valid);
      pid_enc  = lowest_set(pid_hits);
      id_ok    = (job_id != '0) && (job_id <= ID_W'(MAX_JOBS));
      id_slot  = SLOT_W'(job_id - ID_W'(1));
      id_hit   = id_ok && slot_valid[id_slot];
   end

   always_comb begin
      match        = '0;
      match.status = ST_NOT_FOUND;
      unique case (op)
         OP_ADD: begin
            if (free_enc[SLOT_W]) begin
               match.hit      = 1'b1;
               match.slot     = free_enc[SLOT_W-1:0];
               match.status   = ST_OK;
               match.set_slot = 1'b1;
            end else begin
               match.status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (id_hit) begin
               match.hit      = 1'b1;
               match.slot     = id_slot;
               match.status   = ST_OK;
               match.clr_slot = 1'b1;
            end
         end
         OP_FIND_ID: begin
            if (id_hit) begin
               match.hit    = 1'b1;
               match.slot   = id_slot;
               match.status = ST_OK;
            end
         end
         OP_FIND_PID: begin
            if (pid_enc[SLOT_W]) begin
               match.hit    = 1'b1;
               match.slot   = pid_enc[SLOT_W-1:0];
               match.status = ST_OK;
            end
         end
         default: begin
            match.status = ST_NOT_FOUND;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/job_id_table_unit.sv =====
// job id table: up to MAX_JOBS jobs, each a job id (1..MAX_JOBS) and a process id
//
// req channel: one command beat (op, job id, process id), valid/stall handshake
//   add takes the lowest free id, delete frees an id, find looks up by id or by
//   process id (lowest id wins among equal process ids)
// rsp channel: one result beat per command (status, id, process id, live count)
//
// path: a command accepted into the command register is loaded into the result
//   register once that register can take a new beat, and shown on rsp from then on
// throughput: one command per cycle while rsp is not stalled; the table is updated
//   at the same edge the result is registered, so a command sees every earlier one
// stall: rsp_stall freezes the result register; the command register then
//   holds and req_stall rises only while it is occupied, so one beat of
//   buffering sits between the two sides
// reset: synchronous; clears both valid flags, all slot valid bits and the
//   live count; process id storage is not cleared (read only from live slots)

`default_nettype none

module job_id_table_unit import jit_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [ID_W-1:0]     req_job_id,
   input  wire logic [PID_W-1:0]    req_proc_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_result_id,
   output logic [PID_W-1:0]         rsp_result_pid,
   output logic [ID_W-1:0]          rsp_entry_count
);

   // command register
   logic               cmd_valid_ff, cmd_valid_in;
   op_type             cmd_op_ff;
   logic [ID_W-1:0]    cmd_id_ff;
   logic [PID_W-1:0]   cmd_pid_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [PID_W-1:0]   rsp_pid_ff, rsp_pid_in;
   logic [ID_W-1:0]    rsp_count_ff, rsp_count_in;

   // job table
   logic [MAX_JOBS-1:0] slot_valid_ff, slot_valid_in;
   logic [PID_W-1:0]    slot_pid_ff [MAX_JOBS];
   logic [CNT_W-1:0]    live_count_ff, live_count_in;

   logic      out_ready;   // result register can take a new beat
   logic      exec;        // command register executes this cycle
   logic      take;        // req beat accepted
   match_type match;

   jit_match u_match (
      .op         (cmd_op_ff),
      .job_id     (cmd_id_ff),
      .proc_id    (cmd_pid_ff),
      .slot_valid (slot_valid_ff),
      .slot_pid   (slot_pid_ff),
      .match      (match)
   );

   // handshake
   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      exec         = cmd_valid_ff && out_ready;
      req_stall    = cmd_valid_ff && !out_ready;
      take         = req_valid && !req_stall;
      cmd_valid_in = take || (cmd_valid_ff && !exec);
      rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);
   end

   // table update and result for the command in flight
   always_comb begin
      slot_valid_in = slot_valid_ff;
      live_count_in = live_count_ff;
      if (exec && match.set_slot) begin
         slot_valid_in[match.slot] = 1'b1;
         live_count_in             = live_count_ff + CNT_W'(1);
      end else if (exec && match.clr_slot) begin
         slot_valid_in[match.slot] = 1'b0;
         live_count_in             = live_count_ff - CNT_W'(1);
      end

      rsp_status_in = match.status;
      rsp_id_in     = match.hit ? ID_W'(match.slot) + ID_W'(1) : '0;
      if (!match.hit) begin
         rsp_pid_in = '0;
      end else if (match.set_slot) begin
         rsp_pid_in = cmd_pid_ff;   // add reports the pid it stores
      end else begin
         rsp_pid_in = slot_pid_ff[match.slot];
      end
      rsp_count_in = ID_W'(live_count_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         live_count_ff <= '0;
      end else begin
         cmd_valid_ff  <= cmd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         live_count_ff <= live_count_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_op_ff  <= op_type'(req_op);
         cmd_id_ff  <= req_job_id;
         cmd_pid_ff <= req_proc_id;
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_pid_ff    <= rsp_pid_in;
         rsp_count_ff  <= rsp_count_in;
      end
      if (exec && match.set_slot) begin
         slot_pid_ff[match.slot] <= cmd_pid_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_result_pid  = rsp_pid_ff;
   assign rsp_entry_count = rsp_count_ff;

   // live count tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      live_count_ff == CNT_W'($countones(slot_valid_ff)))
      else $error("live count out of step with slot valid bits");

   // a miss or full result carries no id and no pid
   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_id_ff == '0) && (rsp_pid_ff == '0))
      else $error("failed command reports an entry");

   // table full is only reported with every slot live
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> rsp_count_ff == ID_W'(MAX_JOBS))
      else $error("table full reported with free slots");

   // table does not move while a result beat is held
   a_hold_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(slot_valid_ff))
      else $error("table changed under a stalled result");

endmodule

`default_nettype wire
